// ===== rtl/qdws_pkg.sv =====
// Shared types and constants for the quadrature decoder speed channel.
// No dependencies.
`default_nettype none
package qdws_pkg;
	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_RESET  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_INVERT = 3'd0,
		REG_PERIOD = 3'd1,
		REG_CPR    = 3'd2,
		REG_NUM    = 3'd3,
		REG_DEN    = 3'd4
	} reg_idx_t;

	localparam int unsigned CFG_W = 16;
	localparam logic [15:0] MINUTE_MS = 16'd60000;

	typedef struct packed {
		logic [1:0]  command;
		logic [1:0]  ab;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] window_change;
		logic signed [31:0] rpm;
		logic [31:0]        window_ms;
		logic [31:0]        invalid_count;
	} out_item_t;

	// step of the x4 decoder: 1 up, -1 down, 0 none or illegal jump
	function automatic logic signed [1:0] step_of(input logic [1:0] prev, input logic [1:0] cur);
		logic [3:0] k;
		k = {prev, cur};
		unique case (k)
			4'd1, 4'd7, 4'd8, 4'd14: step_of = 2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: step_of = -2'sd1;
			default: step_of = 2'sd0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== rtl/qdws_div.sv =====
// Radix-2 restoring divider, 64 by 64 bits, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none
module qdws_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);
	logic [63:0] rem_q, quo_q, dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== rtl/qdws_ring.sv =====
// Endpoint ring memory: count and time per entry, one write and one read port,
// registered read data. Depends on nothing.
`default_nettype none
module qdws_ring #(
	parameter int unsigned DEPTH = 9,
	parameter int unsigned AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [63:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic [63:0]        rdata
);
	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/quadrature_decoder_window_speed_core.sv =====
// Quadrature decoder channel with windowed speed measurement.
// Depends on qdws_pkg, qdws_ring and qdws_div.
//
// One x4 decoder channel. Pin-sample, unknown, reset and non-capturing tick
// items go from ST_IDLE to ST_OUT: the result is registered there once the
// output register is free, and the input reopens back in ST_IDLE. A tick that
// captures an endpoint writes the ring; while the ring is not yet full it
// passes through ST_READ to ST_OUT. Once the ring is full it reads the oldest
// endpoint back (registered read data), forms the product |delta|*60000*den
// and the divisor cpr*num*elapsed in ST_MUL1 and ST_MUL2, then runs the
// serial divider and registers the result in ST_OUT (the divider is skipped
// when the divisor is zero). One item is worked on at a time; the finished
// result sits in an output register, and the next item is taken while it
// waits.
// Ring contents are undefined after reset; the fill count keeps them unread.
`default_nettype none
module quadrature_decoder_window_speed_core
	import qdws_pkg::*;
#(
	parameter int unsigned WINDOW_ENDPOINTS = 9
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_data,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata
);
	localparam int unsigned AW = $clog2(WINDOW_ENDPOINTS);
	localparam int unsigned FW = $clog2(WINDOW_ENDPOINTS + 1);
	localparam logic [AW-1:0] LAST = AW'(WINDOW_ENDPOINTS - 1);
	localparam logic [FW-1:0] FULL = FW'(WINDOW_ENDPOINTS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_DIFF, ST_MUL1, ST_MUL2, ST_MUL3, ST_DIVW, ST_DONE, ST_OUT
	} state_t;

	// configuration
	logic        inv_q;
	logic [9:0]  period_q;
	logic [15:0] cpr_q, num_q, den_q;

	// channel state
	state_t         state_q;
	logic           armed_q;
	logic [1:0]     last_ab_q;
	logic [31:0]    count_q, bad_q, cap_time_q;
	logic [AW-1:0]  head_q;
	logic [FW-1:0]  fill_q;
	logic [31:0]    rpm_q, delta_q, elapsed_q;
	logic           neg_q;
	logic [31:0]    mag_q;
	logic [47:0]    p1_q;       // mag*60000
	logic [63:0]    prod_q, dvs_q;
	logic           full_q;

	// ring
	logic          ring_we;
	logic [AW-1:0] ring_waddr, ring_raddr, nxt_head;
	logic [63:0]   ring_wdata, ring_rdata;

	// divider
	logic        div_start, div_done;
	logic [63:0] div_quo;
	logic [63:0] div_in;

	logic accept, out_take, out_load;
	assign accept   = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	// load the output register when it is empty or drains this cycle
	assign out_load = (state_q == ST_OUT) && (!out_valid || !out_stall);
	assign in_stall = !(state_q == ST_IDLE);

	assign nxt_head = (head_q == LAST) ? '0 : head_q + AW'(1);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q    <= 1'b0;
			period_q <= 10'd10;
			cpr_q    <= 16'd1;
			num_q    <= 16'd1;
			den_q    <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INVERT: inv_q    <= cfg_wdata[0];
				REG_PERIOD: period_q <= cfg_wdata[9:0];
				REG_CPR:    cpr_q    <= cfg_wdata;
				REG_NUM:    num_q    <= cfg_wdata;
				REG_DEN:    den_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ring write at the new head on capture and on channel reset
	logic         tick_cap;
	logic signed [1:0] stp;
	assign tick_cap = accept && in_data.command == CMD_TICK && armed_q &&
		((in_data.now_ms - cap_time_q) >= {22'd0, period_q});
	assign stp = step_of(last_ab_q, in_data.ab);

	always_comb begin
		ring_we    = 1'b0;
		ring_waddr = nxt_head;
		ring_wdata = {count_q, in_data.now_ms};
		if (tick_cap) ring_we = 1'b1;
		else if (accept && in_data.command == CMD_RESET) begin
			ring_we    = 1'b1;
			ring_waddr = '0;
			ring_wdata = {32'd0, in_data.now_ms};
		end
	end
	// oldest entry sits one beyond the new head
	assign ring_raddr = (head_q == LAST) ? '0 : head_q + AW'(1);

	qdws_ring #(.DEPTH(WINDOW_ENDPOINTS), .AW(AW)) u_ring (
		.clk, .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
		.raddr(ring_raddr), .rdata(ring_rdata)
	);

	// dividend carries the rounding term, added once the divisor is known
	assign div_in = prod_q + {1'b0, dvs_q[63:1]};

	assign div_start = (state_q == ST_MUL3) && (dvs_q != 64'd0);
	qdws_div u_div (
		.clk, .arst_n, .start(div_start), .dividend(div_in), .divisor(dvs_q),
		.done(div_done), .quotient(div_quo)
	);

	logic [31:0] dc;
	assign dc = count_q - ring_rdata[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			armed_q    <= 1'b0;
			last_ab_q  <= '0;
			count_q    <= '0;
			bad_q      <= '0;
			cap_time_q <= '0;
			head_q     <= '0;
			fill_q     <= '0;
			rpm_q      <= '0;
			delta_q    <= '0;
			elapsed_q  <= '0;
			out_valid  <= 1'b0;
			out_data   <= '0;
			full_q     <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid              <= 1'b1;
				out_data.position      <= count_q;
				out_data.window_change <= delta_q;
				out_data.rpm           <= rpm_q;
				out_data.window_ms     <= elapsed_q;
				out_data.invalid_count <= bad_q;
			end else if (out_take) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (accept) begin
					state_q <= ST_OUT;
					unique case (in_data.command)
						CMD_SAMPLE: begin
							last_ab_q <= in_data.ab;
							if (stp == 2'sd0) begin
								if (in_data.ab != last_ab_q) bad_q <= bad_q + 32'd1;
							end else if ((stp == 2'sd1) ^ inv_q) count_q <= count_q + 32'd1;
							else count_q <= count_q - 32'd1;
						end
						CMD_TICK: if (tick_cap) begin
							cap_time_q <= in_data.now_ms;
							head_q     <= nxt_head;
							if (fill_q != FULL) fill_q <= fill_q + FW'(1);
							full_q <= (fill_q >= FW'(WINDOW_ENDPOINTS - 1));
							state_q <= ST_READ;
						end
						CMD_RESET: begin
							count_q    <= '0;
							bad_q      <= '0;
							rpm_q      <= '0;
							delta_q    <= '0;
							elapsed_q  <= '0;
							head_q     <= '0;
							fill_q     <= FW'(1);
							last_ab_q  <= in_data.ab;
							cap_time_q <= in_data.now_ms;
							armed_q    <= 1'b1;
						end
						default: ;
					endcase
				end
				ST_READ: begin
					// read of the oldest entry is under way
					if (full_q) state_q <= ST_DIFF;
					else begin
						rpm_q <= '0; delta_q <= '0; elapsed_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_DIFF: begin
					delta_q   <= dc;
					elapsed_q <= cap_time_q - ring_rdata[31:0];
					neg_q     <= dc[31];
					mag_q     <= dc[31] ? (~dc + 32'd1) : dc;
					state_q   <= ST_MUL1;
				end
				ST_MUL1: begin
					p1_q    <= {16'd0, mag_q} * {32'd0, MINUTE_MS};
					dvs_q   <= {32'd0, 32'(cpr_q) * 32'(num_q)};
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					prod_q  <= p1_q * {32'd0, den_q};
					dvs_q   <= dvs_q[31:0] * elapsed_q;
					state_q <= ST_MUL3;
				end
				ST_MUL3: begin
					// round half away: add half the divisor to the magnitude
					if (dvs_q == 64'd0) begin
						rpm_q   <= '0;
						state_q <= ST_OUT;
					end else state_q <= ST_DIVW;
				end
				ST_DIVW: if (div_done) state_q <= ST_DONE;
				ST_DONE: begin
					if (neg_q) rpm_q <= (div_quo > 64'h8000_0000) ? 32'h8000_0000
						: (32'd0 - div_quo[31:0]);
					else rpm_q <= (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
						: div_quo[31:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
